### design/pva_pkg.sv
// shared types and constants for the voice allocator
package pva_pkg;

  localparam int VOICES  = 32;
  localparam int NOTES   = 128;
  localparam int VOICE_W = $clog2(VOICES);
  localparam int NOTE_W  = $clog2(NOTES);
  localparam int VEL_W   = 7;
  localparam int FREQ_W  = 32;
  localparam int STAMP_W = 32;
  localparam int ACT_W   = 3;

  // event kinds
  localparam logic [1:0] KIND_ON   = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;
  localparam logic [1:0] KIND_UP   = 2'd3;

  // voice command actions
  localparam logic [ACT_W-1:0] ACT_START     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RETRIG    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STEAL_REL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STEAL_ANY = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RELEASE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_STOP      = 3'd5;

  // one voice entry as seen by the scan unit
  typedef struct packed {
    logic               busy;
    logic               rel;
    logic [NOTE_W-1:0]  key;
    logic [STAMP_W-1:0] stamp;
  } voice_rec_t;

  // outcome of a full voice scan
  typedef struct packed {
    logic               found;
    logic [VOICE_W-1:0] found_idx;
    logic               free_ok;
    logic [VOICE_W-1:0] free_idx;
    logic               rel_ok;
    logic [VOICE_W-1:0] rel_idx;
    logic [VOICE_W-1:0] any_idx;
  } scan_res_t;

  // voice command, last field in the lowest bits
  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [VEL_W-1:0]   vel;
    logic [NOTE_W-1:0]  note;
    logic [ACT_W-1:0]   action;
    logic [VOICE_W-1:0] voice;
  } cmd_t;

  localparam int CMD_W   = $bits(cmd_t);
  localparam int MDATA_W = ((CMD_W + 7) / 8) * 8;
  localparam int SDATA_W = ((NOTE_W + VEL_W + FREQ_W + 7) / 8) * 8;

endpackage

### design/polyphonic_voice_allocator_top.sv
// voice allocator top level: sequencer, voice state and pedal state
//
//  channel  dir  tdata                            tuser                  tlast
//  s_*      in   note, velocity, frequency_word   kind, immediate        -
//  m_*      out  voice_index, action, note_out,   -                      last
//                velocity_out, frequency_out
//
// note events pass every voice in turn through the shared scan unit, then
// apply the command, if any, and hand it off. pedal-up walks all 128 notes
// and runs a voice scan and release for each sustained note. pedal-down and
// deferred note-off skip the scan and go straight to the hand-off.
// s_tready is high only between events; the sequencer waits while the
// output register is full.
// reset clears voices, pedal and sustain marks at once, no clearing pass.
module polyphonic_voice_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // note, velocity, frequency_word, zero pad
  input  logic [pva_pkg::SDATA_W-1:0]   s_tdata,
  // kind, immediate
  input  logic [2:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // voice_index, action, note_out, velocity_out, frequency_out, zero pad
  output logic [pva_pkg::MDATA_W-1:0]   m_tdata,
  output logic                          m_tlast
);
  import pva_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_PED, S_DONE} state_t;
  typedef enum logic [1:0] {M_ON, M_STOP, M_REL} mode_t;

  state_t             state;
  mode_t              mode;
  logic               from_ped;
  logic [NOTE_W-1:0]  tgt;
  logic [VEL_W-1:0]   vel_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [VOICE_W-1:0] vi;
  logic [NOTE_W-1:0]  k;
  logic [STAMP_W-1:0] evcount;
  logic               ped;
  logic [NOTES-1:0]   sust;

  logic [VOICES-1:0]  busy;
  logic [VOICES-1:0]  rel;
  logic [NOTE_W-1:0]  key   [VOICES];
  logic [STAMP_W-1:0] stamp [VOICES];

  cmd_t               pend;
  logic               pend_valid;

  // input fields
  logic [1:0]         in_kind;
  logic               in_imm;
  logic [NOTE_W-1:0]  in_note;
  logic [VEL_W-1:0]   in_vel;
  logic [FREQ_W-1:0]  in_freq;
  logic               in_go;

  assign in_kind = s_tuser[1:0];
  assign in_imm  = s_tuser[2];
  assign in_note = s_tdata[NOTE_W-1:0];
  assign in_vel  = s_tdata[NOTE_W+VEL_W-1:NOTE_W];
  assign in_freq = s_tdata[NOTE_W+VEL_W+FREQ_W-1:NOTE_W+VEL_W];
  assign s_tready = (state == S_IDLE);
  assign in_go    = s_tvalid && s_tready;

  // shared scan unit
  voice_rec_t rec;
  scan_res_t  res;
  logic       scan_step;

  assign rec.busy  = busy[vi];
  assign rec.rel   = rel[vi];
  assign rec.key   = key[vi];
  assign rec.stamp = stamp[vi];
  assign scan_step = (state == S_SCAN);

  pva_scan_unit u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (scan_step),
    .first   (vi == '0),
    .idx     (vi),
    .rec     (rec),
    .target  (tgt),
    .evcount (evcount),
    .res     (res)
  );

  // command chosen from the scan outcome
  cmd_t cmd;
  logic cmd_ok;
  logic out_free;
  logic apply_go;
  logic out_load;
  logic out_last;
  logic ped_end;

  always_comb begin
    cmd.note = tgt;
    cmd.vel  = '0;
    cmd.freq = '0;
    cmd_ok   = res.found;
    cmd.voice  = res.found_idx;
    cmd.action = ACT_RELEASE;
    case (mode)
      M_ON: begin
        cmd_ok  = 1'b1;
        cmd.vel = vel_r;
        if (res.found) begin
          cmd.action = ACT_RETRIG;
        end else if (res.free_ok) begin
          cmd.voice  = res.free_idx;
          cmd.action = ACT_START;
          cmd.freq   = freq_r;
        end else if (res.rel_ok) begin
          cmd.voice  = res.rel_idx;
          cmd.action = ACT_STEAL_REL;
          cmd.freq   = freq_r;
        end else begin
          cmd.voice  = res.any_idx;
          cmd.action = ACT_STEAL_ANY;
          cmd.freq   = freq_r;
        end
      end
      M_STOP:  cmd.action = ACT_STOP;
      default: cmd.action = ACT_RELEASE;
    endcase
  end

  assign apply_go = (state == S_APPLY) && (!cmd_ok || !pend_valid || out_free);
  assign out_last = (state == S_DONE);
  assign out_load = (apply_go && cmd_ok && pend_valid) ||
                    ((state == S_DONE) && pend_valid && out_free);
  assign ped_end  = (k == NOTE_W'(NOTES - 1));

  pva_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .cmd      (pend),
    .cmd_last (out_last),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // sequencer, voice state and pedal state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_ON;
      from_ped   <= 1'b0;
      vi         <= '0;
      k          <= '0;
      evcount    <= '0;
      ped        <= 1'b0;
      sust       <= '0;
      busy       <= '0;
      rel        <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_go) begin
            evcount  <= evcount + 1'b1;
            tgt      <= in_note;
            vel_r    <= in_vel;
            freq_r   <= in_freq;
            vi       <= '0;
            k        <= '0;
            from_ped <= 1'b0;
            unique case (in_kind)
              KIND_ON: begin
                sust[in_note] <= 1'b0;
                mode          <= M_ON;
                state         <= S_SCAN;
              end
              KIND_OFF: begin
                if (in_imm) begin
                  mode  <= M_STOP;
                  state <= S_SCAN;
                end else if (ped) begin
                  sust[in_note] <= 1'b1;
                  state         <= S_DONE;
                end else begin
                  mode  <= M_REL;
                  state <= S_SCAN;
                end
              end
              KIND_DOWN: begin
                ped   <= 1'b1;
                state <= S_DONE;
              end
              default: state <= S_PED;
            endcase
          end
        end
        S_SCAN: begin
          vi <= vi + 1'b1;
          if (vi == VOICE_W'(VOICES - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            if (cmd_ok) begin
              pend       <= cmd;
              pend_valid <= 1'b1;
              stamp[cmd.voice] <= evcount;
              case (mode)
                M_ON: begin
                  rel[cmd.voice]  <= 1'b0;
                  busy[cmd.voice] <= 1'b1;
                  key[cmd.voice]  <= tgt;
                end
                M_STOP: begin
                  busy[cmd.voice] <= 1'b0;
                  rel[cmd.voice]  <= 1'b0;
                end
                default: rel[cmd.voice] <= 1'b1;
              endcase
            end
            if (!from_ped) begin
              state <= S_DONE;
            end else if (ped_end) begin
              sust  <= '0;
              ped   <= 1'b0;
              state <= S_DONE;
            end else begin
              k     <= k + 1'b1;
              state <= S_PED;
            end
          end
        end
        S_PED: begin
          if (sust[k]) begin
            tgt      <= k;
            mode     <= M_REL;
            from_ped <= 1'b1;
            vi       <= '0;
            state    <= S_SCAN;
          end else if (ped_end) begin
            sust  <= '0;
            ped   <= 1'b0;
            state <= S_DONE;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DONE: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no command may be left pending between events
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending command left at idle");

  // every accepted event advances the counter by one
  a_evcount: assert property (@(posedge clk) disable iff (rst)
    in_go |=> evcount == $past(evcount) + 1'b1)
    else $error("event counter did not advance");

  // end of a pedal-up walk clears the pedal and every sustain mark
  a_ped_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_PED && !sust[k] && ped_end) |=> (!ped && sust == '0))
    else $error("pedal-up left sustain state");

  // a note-on always produces a command when applied
  a_on_cmd: assert property (@(posedge clk) disable iff (rst)
    (apply_go && mode == M_ON) |=> pend_valid)
    else $error("note-on produced no command");

endmodule

### design/pva_scan_unit.sv
// shared compare and age unit, visits one voice per cycle while step is high
module pva_scan_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          first,
  input  logic [pva_pkg::VOICE_W-1:0]   idx,
  input  pva_pkg::voice_rec_t           rec,
  input  logic [pva_pkg::NOTE_W-1:0]    target,
  input  logic [pva_pkg::STAMP_W-1:0]   evcount,
  output pva_pkg::scan_res_t            res
);
  import pva_pkg::*;

  logic [STAMP_W-1:0] age;
  logic [STAMP_W-1:0] rel_age;
  logic [STAMP_W-1:0] any_age;
  logic               match;

  // wrapping age and key match of the visited voice
  assign age   = evcount - rec.stamp;
  assign match = rec.busy && (rec.key == target);

  // running candidates, lowest index wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      res.found   <= 1'b0;
      res.free_ok <= 1'b0;
      res.rel_ok  <= 1'b0;
    end else if (step) begin
      if (first) begin
        res.found     <= match;
        res.found_idx <= idx;
        res.free_ok   <= !rec.busy;
        res.free_idx  <= idx;
        res.rel_ok    <= rec.rel;
        res.rel_idx   <= idx;
        rel_age       <= age;
        res.any_idx   <= idx;
        any_age       <= age;
      end else begin
        if (match && !res.found) begin
          res.found     <= 1'b1;
          res.found_idx <= idx;
        end
        if (!rec.busy && !res.free_ok) begin
          res.free_ok  <= 1'b1;
          res.free_idx <= idx;
        end
        if (rec.rel && (!res.rel_ok || age > rel_age)) begin
          res.rel_ok  <= 1'b1;
          res.rel_idx <= idx;
          rel_age     <= age;
        end
        if (age > any_age) begin
          res.any_idx <= idx;
          any_age     <= age;
        end
      end
    end
  end

endmodule

### design/pva_out_stage.sv
// output register for voice commands
module pva_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  pva_pkg::cmd_t                 cmd,
  input  logic                          cmd_last,
  output logic                          out_free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // voice_index, action, note_out, velocity_out, frequency_out, zero pad
  output logic [pva_pkg::MDATA_W-1:0]   m_tdata,
  output logic                          m_tlast
);
  import pva_pkg::*;

  assign out_free = !m_tvalid || m_tready;

  // hold one command until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= MDATA_W'(cmd);
      m_tlast  <= cmd_last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
